// ----- rtl/prst_pkg.sv -----
// Shared types and constants for the mutable 2D prefix-sum table.
`timescale 1ns / 1ps

package prst_pkg;

   // Fixed field widths of the request, response and CSR port.
   localparam int ROW_W     = 6;
   localparam int COL_W     = 6;
   localparam int VALUE_W   = 16;
   localparam int SUM_W     = 32;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 1'b1;

   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_OLD,
      ST_SWEEP,
      ST_QUERY,
      ST_RESP
   } seq_state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [SUM_W-1:0] a;
      logic [SUM_W-1:0] b;
   } alu_req_type;

endpackage

// ----- rtl/prst_if.sv -----
// Request and response channel interfaces of the prefix-sum table.
`timescale 1ns / 1ps

interface prst_req_if;
   import prst_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [ROW_W-1:0]          row;
   logic [COL_W-1:0]          col;
   logic [ROW_W-1:0]          row_end;
   logic [COL_W-1:0]          col_end;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, req_type, row, col, row_end, col_end, value,
                   input ready);
   modport sink (input valid, req_type, row, col, row_end, col_end, value,
                 output ready);
endinterface

interface prst_rsp_if;
   import prst_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [SUM_W-1:0] region_sum;
   logic                    status;

   modport source (output valid, region_sum, status, input ready);
   modport sink (input valid, region_sum, status, output ready);
endinterface

// ----- rtl/prst_ram.sv -----
// Simple dual-port memory with one write port and a registered read port.
`timescale 1ns / 1ps

module prst_ram #(
   parameter int AW = 13,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);
   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/prst_alu.sv -----
// Shared 32-bit add/subtract unit used by the update and query steps of the sequencer.
`timescale 1ns / 1ps

module prst_alu (
   input  prst_pkg::alu_req_type       alu_req,
   output logic [prst_pkg::SUM_W-1:0]  alu_res
);
   import prst_pkg::*;

   always_comb begin
      case (alu_req.op)
         ALU_ADD: alu_res = alu_req.a + alu_req.b;
         ALU_SUB: alu_res = alu_req.a - alu_req.b;
         default: alu_res = alu_req.a;
      endcase
   end
endmodule

// ----- rtl/prst_seq.sv -----
// Sequencer: clearing pass, update sweep, four-read query and response register.
`timescale 1ns / 1ps

module prst_seq #(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_COLS   = 64,
   parameter int CELL_WIDTH = 16,
   parameter int RW         = $clog2(MAX_ROWS + 1),
   parameter int CW         = $clog2(MAX_COLS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [prst_pkg::CFG_W-1:0]    rows_in_use,
   input  logic [prst_pkg::CFG_W-1:0]    cols_in_use,
   prst_req_if.sink                      req_if,
   prst_rsp_if.source                    rsp_if,
   output prst_pkg::alu_req_type         alu_req,
   input  logic [prst_pkg::SUM_W-1:0]    alu_res,
   output logic                          cell_we,
   output logic [RW+CW-1:0]              cell_waddr,
   output logic [CELL_WIDTH-1:0]         cell_wdata,
   output logic                          cell_re,
   output logic [RW+CW-1:0]              cell_raddr,
   input  logic [CELL_WIDTH-1:0]         cell_rdata,
   output logic                          tbl_we,
   output logic [RW+CW-1:0]              tbl_waddr,
   output logic [prst_pkg::SUM_W-1:0]    tbl_wdata,
   output logic                          tbl_re,
   output logic [RW+CW-1:0]              tbl_raddr,
   input  logic [prst_pkg::SUM_W-1:0]    tbl_rdata
);
   import prst_pkg::*;

   localparam int CMPW_R = (RW > CFG_W) ? RW : CFG_W;
   localparam int CMPW_C = (CW > CFG_W) ? CW : CFG_W;
   localparam logic [2:0] QSTEP_LAST = 3'd4;

   seq_state_type state_ff, state_in;

   logic [RW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [RW-1:0] wi_ff, wi_in;
   logic [CW-1:0] wj_ff, wj_in;
   logic          pend_ff, pend_in;
   logic          rd_act_ff, rd_act_in;
   logic [2:0]    step_ff, step_in;

   logic                         kind_ff, kind_in;
   logic                         err_ff, err_in;
   logic [RW-1:0]                r0_ff, r0_in, r1_ff, r1_in;
   logic [CW-1:0]                c0_ff, c0_in, c1_ff, c1_in;
   logic signed [CELL_WIDTH-1:0] cell_ff, cell_in;
   logic [SUM_W-1:0]             delta_ff, delta_in;
   logic [SUM_W-1:0]             acc_ff, acc_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic                    rsp_status_ff, rsp_status_in;

   logic                    accept;
   logic                    rsp_free;
   logic                    req_err;
   logic                    upd_err;
   logic                    qry_err;
   logic                    clr_last;
   logic                    row_last;
   logic                    col_last;
   logic signed [SUM_W-1:0] val_ext;
   logic [CMPW_R-1:0]       row_x, row_end_x, rows_x;
   logic [CMPW_C-1:0]       col_x, col_end_x, cols_x;

   assign accept   = req_if.valid && req_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   assign row_x     = CMPW_R'(req_if.row);
   assign row_end_x = CMPW_R'(req_if.row_end);
   assign rows_x    = CMPW_R'(rows_in_use);
   assign col_x     = CMPW_C'(req_if.col);
   assign col_end_x = CMPW_C'(req_if.col_end);
   assign cols_x    = CMPW_C'(cols_in_use);

   assign upd_err = (row_x >= rows_x) || (col_x >= cols_x);
   assign qry_err = (row_x > row_end_x) || (col_x > col_end_x) ||
                    (row_end_x >= rows_x) || (col_end_x >= cols_x);
   assign req_err = (req_if.req_type == REQ_QUERY) ? qry_err : upd_err;
   assign val_ext = SUM_W'(req_if.value);

   assign row_last = (CMPW_R'(i_ff) == rows_x);
   assign col_last = (CMPW_C'(j_ff) == cols_x);
   assign clr_last = (i_ff == RW'(MAX_ROWS)) && (j_ff == CW'(MAX_COLS));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_err) begin
                  state_in = ST_RESP;
               end else if (req_if.req_type == REQ_QUERY) begin
                  state_in = ST_QUERY;
               end else begin
                  state_in = ST_UPD_OLD;
               end
            end
         end
         ST_UPD_OLD: state_in = ST_SWEEP;
         ST_SWEEP: begin
            if (!rd_act_ff && pend_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_QUERY: begin
            if (step_ff == QSTEP_LAST) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory ports, shared unit and handshake.
   always_comb begin
      req_if.ready = (state_ff == ST_IDLE);
      alu_req      = '{op: ALU_ADD, a: '0, b: '0};
      cell_we      = 1'b0;
      cell_waddr   = {r0_ff, c0_ff};
      cell_wdata   = cell_ff;
      cell_re      = accept;
      cell_raddr   = {RW'(req_if.row), CW'(req_if.col)};
      tbl_we       = 1'b0;
      tbl_waddr    = {wi_ff, wj_ff};
      tbl_wdata    = alu_res;
      tbl_re       = 1'b0;
      tbl_raddr    = {i_ff, j_ff};
      case (state_ff)
         ST_CLEAR: begin
            tbl_we     = 1'b1;
            tbl_waddr  = {i_ff, j_ff};
            tbl_wdata  = '0;
            cell_we    = (i_ff < RW'(MAX_ROWS)) && (j_ff < CW'(MAX_COLS));
            cell_waddr = {i_ff, j_ff};
            cell_wdata = '0;
         end
         ST_UPD_OLD: begin
            // The old cell arrives now; the change is new minus old.
            alu_req = '{op: ALU_SUB, a: SUM_W'(cell_ff), b: SUM_W'($signed(cell_rdata))};
            cell_we = 1'b1;
         end
         ST_SWEEP: begin
            tbl_re  = rd_act_ff;
            tbl_we  = pend_ff;
            alu_req = '{op: ALU_ADD, a: tbl_rdata, b: delta_ff};
         end
         ST_QUERY: begin
            tbl_re = (step_ff != QSTEP_LAST);
            case (step_ff)
               3'd0: tbl_raddr = {r1_ff + RW'(1), c1_ff + CW'(1)};
               3'd1: tbl_raddr = {r0_ff, c1_ff + CW'(1)};
               3'd2: tbl_raddr = {r1_ff + RW'(1), c0_ff};
               default: tbl_raddr = {r0_ff, c0_ff};
            endcase
            case (step_ff)
               3'd1: alu_req = '{op: ALU_ADD, a: '0, b: tbl_rdata};
               3'd2: alu_req = '{op: ALU_SUB, a: acc_ff, b: tbl_rdata};
               3'd3: alu_req = '{op: ALU_SUB, a: acc_ff, b: tbl_rdata};
               3'd4: alu_req = '{op: ALU_ADD, a: acc_ff, b: tbl_rdata};
               default: alu_req = '{op: ALU_ADD, a: '0, b: '0};
            endcase
         end
         default: begin
         end
      endcase
   end

   // Datapath register updates.
   always_comb begin
      i_in          = i_ff;
      j_in          = j_ff;
      wi_in         = wi_ff;
      wj_in         = wj_ff;
      pend_in       = pend_ff;
      rd_act_in     = rd_act_ff;
      step_in       = step_ff;
      kind_in       = kind_ff;
      err_in        = err_ff;
      r0_in         = r0_ff;
      r1_in         = r1_ff;
      c0_in         = c0_ff;
      c1_in         = c1_ff;
      cell_in       = cell_ff;
      delta_in      = delta_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (j_ff == CW'(MAX_COLS)) begin
               j_in = '0;
               i_in = i_ff + RW'(1);
            end else begin
               j_in = j_ff + CW'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in   = req_if.req_type;
               err_in    = req_err;
               r0_in     = RW'(req_if.row);
               c0_in     = CW'(req_if.col);
               r1_in     = RW'(req_if.row_end);
               c1_in     = CW'(req_if.col_end);
               cell_in   = val_ext[CELL_WIDTH-1:0];
               i_in      = RW'(req_if.row) + RW'(1);
               j_in      = CW'(req_if.col) + CW'(1);
               rd_act_in = 1'b1;
               pend_in   = 1'b0;
               step_in   = '0;
            end
         end
         ST_UPD_OLD: delta_in = alu_res;
         ST_SWEEP: begin
            // Reads run one entry ahead of the write-back.
            pend_in = rd_act_ff;
            if (rd_act_ff) begin
               wi_in = i_ff;
               wj_in = j_ff;
               if (row_last && col_last) begin
                  rd_act_in = 1'b0;
               end else if (col_last) begin
                  j_in = c0_ff + CW'(1);
                  i_in = i_ff + RW'(1);
               end else begin
                  j_in = j_ff + CW'(1);
               end
            end
         end
         ST_QUERY: begin
            step_in = step_ff + 3'd1;
            if (step_ff != 3'd0) begin
               acc_in = alu_res;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = err_ff ? STATUS_ERROR : STATUS_DONE;
               rsp_sum_in    = (err_ff || kind_ff == REQ_UPDATE) ? '0 : acc_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         i_ff         <= '0;
         j_ff         <= '0;
         pend_ff      <= 1'b0;
         rd_act_ff    <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         pend_ff      <= pend_in;
         rd_act_ff    <= rd_act_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wi_ff         <= wi_in;
      wj_ff         <= wj_in;
      kind_ff       <= kind_in;
      err_ff        <= err_in;
      r0_ff         <= r0_in;
      r1_ff         <= r1_in;
      c0_ff         <= c0_in;
      c1_ff         <= c1_in;
      cell_ff       <= cell_in;
      delta_ff      <= delta_in;
      acc_ff        <= acc_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.region_sum = rsp_sum_ff;
   assign rsp_if.status     = rsp_status_ff;
endmodule

// ----- rtl/mutable_2d_prefix_sum_table_top.sv -----
// Top level of the mutable 2D prefix-sum table: size registers, memories and sequencer.
//
//   Port      Dir  Handshake          Moves
//   req_if    in   valid/ready        one request: update of a cell or rectangle query
//   rsp_if    out  valid/ready        one response per request: region_sum, status
//   csr_*     in   csr_wr_en          write of rows_in_use (index 0) or cols_in_use (index 1)
//
// An update sweeps the (rows_in_use - row) * (cols_in_use - col) prefix entries that cover
// the cell: one read-modify-write of the prefix memory per cycle through the shared
// adder. A query makes four reads of the prefix memory; a rejected request goes
// straight to the response. After reset a clearing pass over (MAX_ROWS + 1) * (MAX_COLS + 1)
// addresses zeroes both memories; no request is taken meanwhile. One request is in flight
// at a time, and a response held by a stalled sink only delays the end of the next request.
`timescale 1ns / 1ps

module mutable_2d_prefix_sum_table_top #(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_COLS   = 64,
   parameter int CELL_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   prst_req_if.sink                          req_if,
   prst_rsp_if.source                        rsp_if,
   input  logic                              csr_wr_en,
   input  logic [prst_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [prst_pkg::CFG_W-1:0]        csr_wdata
);
   import prst_pkg::*;

   localparam int RW   = $clog2(MAX_ROWS + 1);
   localparam int CW   = $clog2(MAX_COLS + 1);
   localparam int AW   = RW + CW;
   localparam int CMPW = ((RW > CW) ? RW : CW) > CFG_W ? ((RW > CW) ? RW : CW) : CFG_W;
   localparam logic [CFG_W-1:0] ROWS_RESET = (MAX_ROWS < 64) ? CFG_W'(MAX_ROWS) : CFG_W'(64);
   localparam logic [CFG_W-1:0] COLS_RESET = (MAX_COLS < 64) ? CFG_W'(MAX_COLS) : CFG_W'(64);

   logic [CFG_W-1:0] rows_in_use_ff, rows_in_use_in;
   logic [CFG_W-1:0] cols_in_use_ff, cols_in_use_in;
   logic [CFG_W-1:0] rows_clamped, cols_clamped;

   alu_req_type                 alu_req;
   logic [SUM_W-1:0]            alu_res;
   logic                        cell_we, cell_re, tbl_we, tbl_re;
   logic [AW-1:0]               cell_waddr, cell_raddr, tbl_waddr, tbl_raddr;
   logic [CELL_WIDTH-1:0]       cell_wdata, cell_rdata;
   logic [SUM_W-1:0]            tbl_wdata, tbl_rdata;

   // A size of zero becomes one; a size above the maximum becomes the maximum.
   always_comb begin
      if (csr_wdata == '0) begin
         rows_clamped = CFG_W'(1);
      end else if (CMPW'(csr_wdata) > CMPW'(MAX_ROWS)) begin
         rows_clamped = CFG_W'(MAX_ROWS);
      end else begin
         rows_clamped = csr_wdata;
      end
      if (csr_wdata == '0) begin
         cols_clamped = CFG_W'(1);
      end else if (CMPW'(csr_wdata) > CMPW'(MAX_COLS)) begin
         cols_clamped = CFG_W'(MAX_COLS);
      end else begin
         cols_clamped = csr_wdata;
      end
   end

   always_comb begin
      rows_in_use_in = rows_in_use_ff;
      cols_in_use_in = cols_in_use_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ROWS_IN_USE: rows_in_use_in = rows_clamped;
            CSR_COLS_IN_USE: cols_in_use_in = cols_clamped;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_in_use_ff <= ROWS_RESET;
         cols_in_use_ff <= COLS_RESET;
      end else begin
         rows_in_use_ff <= rows_in_use_in;
         cols_in_use_ff <= cols_in_use_in;
      end
   end

   prst_ram #(.AW(AW), .DW(CELL_WIDTH)) u_cell_ram (
      .clock (clock),
      .we    (cell_we),
      .waddr (cell_waddr),
      .wdata (cell_wdata),
      .re    (cell_re),
      .raddr (cell_raddr),
      .rdata (cell_rdata)
   );

   prst_ram #(.AW(AW), .DW(SUM_W)) u_tbl_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .re    (tbl_re),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   prst_alu u_alu (
      .alu_req (alu_req),
      .alu_res (alu_res)
   );

   prst_seq #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .CELL_WIDTH (CELL_WIDTH),
      .RW         (RW),
      .CW         (CW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .rows_in_use (rows_in_use_ff),
      .cols_in_use (cols_in_use_ff),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .alu_req     (alu_req),
      .alu_res     (alu_res),
      .cell_we     (cell_we),
      .cell_waddr  (cell_waddr),
      .cell_wdata  (cell_wdata),
      .cell_re     (cell_re),
      .cell_raddr  (cell_raddr),
      .cell_rdata  (cell_rdata),
      .tbl_we      (tbl_we),
      .tbl_waddr   (tbl_waddr),
      .tbl_wdata   (tbl_wdata),
      .tbl_re      (tbl_re),
      .tbl_raddr   (tbl_raddr),
      .tbl_rdata   (tbl_rdata)
   );
endmodule

// ----- rtl/prst_chk.sv -----
// Port-level checks of the prefix-sum table, bound to the top level.
`timescale 1ns / 1ps

module prst_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [prst_pkg::SUM_W-1:0]   rsp_region_sum,
   input logic                         rsp_status
);
   import prst_pkg::*;

   // Only one request is worked on at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   // Rejected requests carry a zero sum.
   a_error_sum_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_ERROR) |-> rsp_region_sum == '0)
      else $error("rejected request returned a nonzero sum");

   // The memories are being cleared right after reset.
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken during the clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_region_sum) && $stable(rsp_status))
      else $error("stalled response changed");
endmodule

bind mutable_2d_prefix_sum_table_top prst_chk u_prst_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_region_sum (rsp_if.region_sum),
   .rsp_status     (rsp_if.status)
);
